/* hw/rtl/ssp_pkg.sv */
// Shared types and constants for the script stream parser.
// No dependencies; used by script_stream_parser.
package ssp_pkg;

  // role tag attached to every byte of the stream
  typedef enum logic [1:0] {
    ROLE_VARINT = 2'd0,
    ROLE_OPCODE = 2'd1,
    ROLE_LEN    = 2'd2,
    ROLE_DATA   = 2'd3
  } role_e;

  // opcode boundaries
  localparam logic [7:0] OP_PUSH_MAX  = 8'd75;
  localparam logic [7:0] OP_PUSHDATA1 = 8'd76;
  localparam logic [7:0] OP_PUSHDATA2 = 8'd77;

  // compact size prefix markers
  localparam logic [7:0] VARINT_U16 = 8'hfd;
  localparam logic [7:0] VARINT_U32 = 8'hfe;

endpackage

/* hw/rtl/script_stream_parser.sv */
// Script stream parser top level: length prefix decode and element split.
// Depends on ssp_pkg for role codes and opcode constants.

// Takes one script byte per item and returns one tagged item per byte: the
// byte and the parser state feed a single level of counter and compare logic
// that lands in the result register, out in the cycle after the byte is taken.
// The block takes one item every cycle, also while a result waits, as long as
// the result register is empty or being drained in the same cycle. Each
// script starts with a compact size length; a zero length ends the script on
// its last length byte. An element that runs past the declared script end
// raises overrun_error on the byte that reveals it, is clipped to the script
// end, and the next byte is taken as a new length prefix.
module script_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  byte_role_o,
  output logic [15:0] element_index_o,
  output logic [15:0] push_length_o,
  output logic        element_end_o,
  output logic        script_end_o,
  output logic        overrun_error_o
);

  typedef enum logic [2:0] {
    PH_VARINT = 3'd0,
    PH_VEXT   = 3'd1,
    PH_OPCODE = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4
  } phase_e;

  // parser state
  phase_e        phase_q, phase_d;
  logic [63:0]   rem_q, rem_d;
  logic [3:0]    vleft_q, vleft_d;
  logic [2:0]    vpos_q, vpos_d;
  logic [15:0]   prem_q, prem_d;
  logic [1:0]    lleft_q, lleft_d;
  logic          lpos_q, lpos_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [15:0]   cpl_q, cpl_d;

  // result register
  logic          out_valid_q;
  logic [7:0]    value_q;
  ssp_pkg::role_e role_q, role_d;
  logic [15:0]   idx_q, idx_d;
  logic [15:0]   plen_q, plen_d;
  logic          eend_q, eend_d;
  logic          send_q, send_d;
  logic          err_q, err_d;

  logic          in_fire;
  logic          body;
  logic [63:0]   rem_dec;
  logic [63:0]   rem_vext;
  logic [15:0]   cpl_new;
  logic [15:0]   decl_len;
  logic          fits;
  logic [15:0]   clipped;
  logic [15:0]   prem_dec;

  // handshake: the result register frees up when drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // shared datapath pieces
  assign rem_dec  = rem_q - 64'd1;
  assign rem_vext = rem_q | ({56'd0, data_byte_i} << {vpos_q, 3'b000});
  assign cpl_new  = cpl_q | (lpos_q ? {data_byte_i, 8'h00} : {8'h00, data_byte_i});
  assign decl_len = (phase_q == PH_LEN) ? cpl_new : {8'h00, data_byte_i};
  assign fits     = (rem_dec[63:16] != 48'd0) || (decl_len <= rem_dec[15:0]);
  assign clipped  = fits ? decl_len : rem_dec[15:0];
  assign prem_dec = prem_q - 16'd1;

  // next state and result
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    vleft_d = vleft_q;
    vpos_d  = vpos_q;
    prem_d  = prem_q;
    lleft_d = lleft_q;
    lpos_d  = lpos_q;
    cnt_d   = cnt_q;
    cpl_d   = cpl_q;
    role_d  = ssp_pkg::ROLE_VARINT;
    idx_d   = 16'd0;
    plen_d  = 16'd0;
    eend_d  = 1'b0;
    send_d  = 1'b0;
    err_d   = 1'b0;
    body    = 1'b0;

    case (phase_q)
      PH_VEXT: begin
        rem_d   = rem_vext;
        vpos_d  = vpos_q + 3'd1;
        vleft_d = vleft_q - 4'd1;
        if (vleft_d == 4'd0 || vpos_q == 3'd7) begin
          vleft_d = 4'd0;
          if (rem_vext == 64'd0) begin
            send_d  = 1'b1;
            phase_d = PH_VARINT;
          end else begin
            phase_d = PH_OPCODE;
            cnt_d   = 16'd0;
          end
        end
      end
      PH_OPCODE: begin
        body   = 1'b1;
        role_d = ssp_pkg::ROLE_OPCODE;
        idx_d  = cnt_q;
        rem_d  = rem_dec;
        if (data_byte_i inside {[8'd1:ssp_pkg::OP_PUSH_MAX]}) begin
          cpl_d  = {8'h00, data_byte_i};
          plen_d = {8'h00, data_byte_i};
          prem_d = clipped;
          err_d  = !fits;
          if (clipped == 16'd0) eend_d = 1'b1;
          else phase_d = PH_DATA;
        end else if (data_byte_i == ssp_pkg::OP_PUSHDATA1 ||
                     data_byte_i == ssp_pkg::OP_PUSHDATA2) begin
          cpl_d  = 16'd0;
          lpos_d = 1'b0;
          // one length byte for pushdata1, two for pushdata2
          if (data_byte_i == ssp_pkg::OP_PUSHDATA1) begin
            err_d = (rem_dec == 64'd0);
            lleft_d = 2'd1;
          end else begin
            err_d = (rem_dec < 64'd2);
            lleft_d = 2'd2;
          end
          if (rem_dec == 64'd0) begin
            eend_d  = 1'b1;
            lleft_d = lleft_q;
          end else begin
            phase_d = PH_LEN;
          end
        end else begin
          cpl_d  = 16'd0;
          eend_d = 1'b1;
        end
      end
      PH_LEN: begin
        body    = 1'b1;
        role_d  = ssp_pkg::ROLE_LEN;
        idx_d   = cnt_q;
        rem_d   = rem_dec;
        cpl_d   = cpl_new;
        lpos_d  = ~lpos_q;
        lleft_d = lleft_q - 2'd1;
        if (lleft_d == 2'd0) begin
          plen_d = cpl_new;
          prem_d = clipped;
          err_d  = !fits;
          if (clipped == 16'd0) eend_d = 1'b1;
          else phase_d = PH_DATA;
        end else if (rem_dec == 64'd0) begin
          lleft_d = 2'd0;
          eend_d  = 1'b1;
        end
      end
      PH_DATA: begin
        body   = 1'b1;
        role_d = ssp_pkg::ROLE_DATA;
        idx_d  = cnt_q;
        plen_d = cpl_q;
        rem_d  = rem_dec;
        prem_d = prem_dec;
        if (prem_dec == 16'd0 || rem_dec == 64'd0) begin
          prem_d = 16'd0;
          eend_d = 1'b1;
        end
      end
      default: begin
        // first byte of the length prefix
        if (data_byte_i < ssp_pkg::VARINT_U16) begin
          rem_d = {56'd0, data_byte_i};
          if (data_byte_i == 8'd0) begin
            send_d  = 1'b1;
            phase_d = PH_VARINT;
          end else begin
            phase_d = PH_OPCODE;
            cnt_d   = 16'd0;
          end
        end else begin
          rem_d   = 64'd0;
          vpos_d  = 3'd0;
          phase_d = PH_VEXT;
          if (data_byte_i == ssp_pkg::VARINT_U16) vleft_d = 4'd2;
          else if (data_byte_i == ssp_pkg::VARINT_U32) vleft_d = 4'd4;
          else vleft_d = 4'd8;
        end
      end
    endcase

    // element close: bump the index, then script end or next opcode
    if (body && eend_d) begin
      if (cnt_q != 16'hffff) cnt_d = cnt_q + 16'd1;
      if (rem_dec == 64'd0) begin
        send_d  = 1'b1;
        phase_d = PH_VARINT;
        cnt_d   = 16'd0;
      end else begin
        phase_d = PH_OPCODE;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_VARINT;
      rem_q       <= 64'd0;
      vleft_q     <= 4'd0;
      vpos_q      <= 3'd0;
      prem_q      <= 16'd0;
      lleft_q     <= 2'd0;
      lpos_q      <= 1'b0;
      cnt_q       <= 16'd0;
      cpl_q       <= 16'd0;
      out_valid_q <= 1'b0;
      value_q     <= 8'd0;
      role_q      <= ssp_pkg::ROLE_VARINT;
      idx_q       <= 16'd0;
      plen_q      <= 16'd0;
      eend_q      <= 1'b0;
      send_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        rem_q       <= rem_d;
        vleft_q     <= vleft_d;
        vpos_q      <= vpos_d;
        prem_q      <= prem_d;
        lleft_q     <= lleft_d;
        lpos_q      <= lpos_d;
        cnt_q       <= cnt_d;
        cpl_q       <= cpl_d;
        out_valid_q <= 1'b1;
        value_q     <= data_byte_i;
        role_q      <= role_d;
        idx_q       <= idx_d;
        plen_q      <= plen_d;
        eend_q      <= eend_d;
        send_q      <= send_d;
        err_q       <= err_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_value_o    = value_q;
  assign byte_role_o     = role_q;
  assign element_index_o = idx_q;
  assign push_length_o   = plen_q;
  assign element_end_o   = eend_q;
  assign script_end_o    = send_q;
  assign overrun_error_o = err_q;

  // opcode and data phases always have script bytes left
  a_opcode_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OPCODE || phase_q == PH_DATA) |-> rem_q != 64'd0)
    else $error("body phase with no script bytes left");

  // data phase always has push bytes left
  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> prem_q != 16'd0)
    else $error("data phase with no push bytes left");

  // a script ending in the body also ends an element
  a_send_with_eend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && send_q && role_q != ssp_pkg::ROLE_VARINT) |-> eend_q)
    else $error("script end without element end");

  // length prefix bytes carry no element info
  a_varint_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && role_q == ssp_pkg::ROLE_VARINT) |->
      (idx_q == 16'd0 && plen_q == 16'd0 && !eend_q && !err_q))
    else $error("length prefix byte with element fields set");

endmodule
